### src/lca_pkg.sv
// Shared constants, types and codes for the life cellular automaton core.
`default_nettype none
package lca_pkg;

  // Grid geometry
  localparam int ROWS  = 32;
  localparam int COLS  = 64;
  localparam int ROW_W = 5;
  localparam int COL_W = 6;
  localparam int CNT_W = $clog2(ROWS + 2);

  // Rule B3/S23
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

  // Command codes
  localparam logic [1:0] FUNC_TOGGLE = 2'd0;
  localparam logic [1:0] FUNC_STEP   = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  typedef logic [COLS-1:0]  row_t;
  typedef logic [ROW_W-1:0] row_idx_t;
  typedef logic [COL_W-1:0] col_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_FETCH,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // Grid memory request from the sequencer
  typedef struct packed {
    logic     re;
    row_idx_t raddr;
    logic     we;
    row_idx_t waddr;
    row_t     wdata;
  } mem_req_t;

endpackage
`default_nettype wire

### src/life_cellular_automaton_core.sv
// Top level of the life cellular automaton core (B3/S23, non-wrapping grid).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per beat: func,
//   cell_row, cell_col. Output channel (out_valid/out_ready) returns one beat
//   with cell_alive for every command, in order.
//   Toggle and read: the row is fetched from the grid memory and updated; a
//   toggle writes it back, a read leaves the grid as it was. out_valid rises
//   after the fetch, update and done states. Step: the grid is swept one row
//   per memory read, a three-row window feeds the row rule and the new row is
//   written back two rows behind the read; out_valid rises once the sweep and
//   the done state are over. Addresses outside the grid and func 3 answer 0.
//   One command at a time: in_ready is high only while the sequencer is idle.
//   The result sits in an output register, so in_ready comes back while an
//   earlier result still waits; a later result waits in the sequencer until
//   the output register frees up. A stalled receiver never loses a beat.
//   Reset (rst, synchronous) clears the row valid bits, so the whole grid
//   reads as dead at once; no clearing pass is needed.
`default_nettype none
module life_cellular_automaton_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                func,
  input  wire logic [lca_pkg::ROW_W-1:0] cell_row,
  input  wire logic [lca_pkg::COL_W-1:0] cell_col,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           cell_alive
);
  import lca_pkg::*;

  mem_req_t mem_req;
  row_t     rdata;
  logic     res_valid;
  logic     res_ready;
  logic     res_bit;

  // output register takes a result when empty or being drained
  assign res_ready = !out_valid || out_ready;

  lca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .cell_row (cell_row),
    .cell_col (cell_col),
    .mem_req  (mem_req),
    .rdata    (rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_bit  (res_bit)
  );

  lca_grid_mem u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      cell_alive <= res_bit;
    end
  end

endmodule
`default_nettype wire

### src/lca_grid_mem.sv
// Grid row memory: one write and one registered read per cycle, valid bit per row.
`default_nettype none
module lca_grid_mem (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lca_pkg::mem_req_t req,
  output logic [lca_pkg::COLS-1:0] rdata
);
  import lca_pkg::*;

  row_t            mem [ROWS];
  logic [ROWS-1:0] vld;
  row_t            rdata_q;
  logic            rvld_q;

  // rows never written since reset read as dead
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld_q <= 1'b0;
    end else if (req.re) begin
      rvld_q <= vld[req.raddr];
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

### src/lca_row_rule.sv
// Next-generation rule for one row from the rows above, at and below it.
`default_nettype none
module lca_row_rule (
  input  wire logic [lca_pkg::COLS-1:0] above,
  input  wire logic [lca_pkg::COLS-1:0] center,
  input  wire logic [lca_pkg::COLS-1:0] below,
  output logic [lca_pkg::COLS-1:0]      next_row
);
  import lca_pkg::*;

  logic [COLS+1:0] ea, ec, eb;

  // dead padding at both edges, cell c sits at bit c+1
  assign ea = {1'b0, above, 1'b0};
  assign ec = {1'b0, center, 1'b0};
  assign eb = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < COLS; c++) begin
      n = {3'b0, ea[c]} + {3'b0, ea[c+1]} + {3'b0, ea[c+2]}
        + {3'b0, ec[c]} + {3'b0, ec[c+2]}
        + {3'b0, eb[c]} + {3'b0, eb[c+1]} + {3'b0, eb[c+2]};
      if (ec[c+1]) begin
        next_row[c] = n inside {[SURVIVE_LOW:SURVIVE_HIGH]};
      end else begin
        next_row[c] = (n == BIRTH_COUNT);
      end
    end
  end

endmodule
`default_nettype wire

### src/lca_ctrl.sv
// Sequencer: row sweep for a generation step, read-modify-write for toggle and read.
`default_nettype none
module lca_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                func,
  input  wire logic [lca_pkg::ROW_W-1:0] cell_row,
  input  wire logic [lca_pkg::COL_W-1:0] cell_col,
  output lca_pkg::mem_req_t              mem_req,
  input  wire logic [lca_pkg::COLS-1:0]  rdata,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output logic                           res_bit
);
  import lca_pkg::*;

  localparam logic [CNT_W-1:0] CNT_ROWS = CNT_W'(ROWS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROWS + 1);
  localparam logic [ROW_W:0]   ROW_LIM  = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]   COL_LIM  = (COL_W + 1)'(COLS);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  row_t             above, above_next;
  row_t             center, center_next;
  row_idx_t         row_q, row_q_next;
  col_idx_t         col_q, col_q_next;
  logic             is_toggle, is_toggle_next;
  logic             res_bit_next;

  logic     accept;
  logic     addr_ok;
  row_t     incoming;
  row_t     rule_row;
  row_t     upd_row;
  row_idx_t cnt_row, wb_row;

  assign accept  = in_valid && in_ready;
  assign addr_ok = ({1'b0, cell_row} < ROW_LIM) && ({1'b0, cell_col} < COL_LIM);
  assign cnt_row = cnt[ROW_W-1:0];
  assign wb_row  = ROW_W'(cnt - CNT_W'(2));

  // row arriving this cycle during a sweep; past the bottom edge it is dead
  assign incoming = (cnt != '0 && cnt <= CNT_ROWS) ? rdata : '0;

  // toggled copy of the fetched row
  assign upd_row = rdata ^ (is_toggle ? (row_t'(1) << col_q) : '0);

  lca_row_rule u_rule (
    .above   (above),
    .center  (center),
    .below   (incoming),
    .next_row(rule_row)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_STEP) begin
            state_next = ST_STEP;
          end else if ((func inside {FUNC_TOGGLE, FUNC_READ}) && addr_ok) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_STEP: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_FETCH:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.raddr = row_q;
    mem_req.we    = 1'b0;
    mem_req.waddr = row_q;
    mem_req.wdata = upd_row;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_STEP: begin
        mem_req.re    = (cnt < CNT_ROWS);
        mem_req.raddr = cnt_row;
        mem_req.we    = (cnt >= CNT_W'(2));
        mem_req.waddr = wb_row;
        mem_req.wdata = rule_row;
      end
      ST_FETCH:  mem_req.re = 1'b1;
      ST_UPDATE: mem_req.we = is_toggle;
      ST_DONE:   res_valid = 1'b1;
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_next       = cnt;
    above_next     = above;
    center_next    = center;
    row_q_next     = row_q;
    col_q_next     = col_q;
    is_toggle_next = is_toggle;
    res_bit_next   = res_bit;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_next       = '0;
          above_next     = '0;
          center_next    = '0;
          row_q_next     = cell_row;
          col_q_next     = cell_col;
          is_toggle_next = (func == FUNC_TOGGLE);
          res_bit_next   = 1'b0;
        end
      end
      ST_STEP: begin
        cnt_next    = cnt + CNT_W'(1);
        above_next  = center;
        center_next = incoming;
      end
      ST_UPDATE: res_bit_next = upd_row[col_q];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    above     <= above_next;
    center    <= center_next;
    row_q     <= row_q_next;
    col_q     <= col_q_next;
    is_toggle <= is_toggle_next;
    res_bit   <= res_bit_next;
  end

  // a step beat always starts a sweep from the top row
  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_STEP) |=> (state == ST_STEP && cnt == '0))
    else $error("step beat did not start a sweep");

  // grid is never written outside a sweep or a toggle update
  a_no_stray_write: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == ST_STEP || (state == ST_UPDATE && is_toggle)))
    else $error("stray grid write");

  // a fetch is always followed by its update
  a_fetch_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |=> (state == ST_UPDATE))
    else $error("fetch not followed by update");

  // a pending result holds while the output side is full
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_bit)))
    else $error("pending result lost");

endmodule
`default_nettype wire
